// ----- src/serial_line_command_decoder_core_defines.svh -----
// Assertion macros shared by the serial line decoder checkers
`ifndef SERIAL_LINE_COMMAND_DECODER_CORE_DEFINES_SVH
`define SERIAL_LINE_COMMAND_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SLD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/sld_pkg.sv -----
// Types, constants and keyword tables of the serial line decoder
package sld_pkg;

   localparam int LINE_CHARS = 64;
   localparam int ADDR_W     = $clog2(LINE_CHARS);
   localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(LINE_CHARS - 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int KEY_COUNT = 8;
   localparam int KEY_W     = $clog2(KEY_COUNT);
   localparam int KEY_MAX   = 6;
   localparam int LEN_W     = $clog2(KEY_MAX + 1);
   localparam int CMP_W     = (ADDR_W > LEN_W) ? ADDR_W : LEN_W;
   localparam logic [KEY_W-1:0] KEY_HELP = KEY_W'(7);

   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_DEL   = 8'h7F;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [7:0] CASE_OFS   = 8'h20;

   localparam logic [1:0] KIND_COMMAND = 2'd0;
   localparam logic [1:0] KIND_HELP    = 2'd1;
   localparam logic [1:0] KIND_INVALID = 2'd2;
   localparam logic [1:0] KIND_RSVD    = 2'd3;

   localparam logic [2:0] CODE_NONE = 3'd0;
   localparam logic [2:0] CODE_RSVD = 3'd7;

   localparam logic [7:0] KEY_TEXT [KEY_COUNT][KEY_MAX] = '{
      '{"s", "t", "a", "r", "t", 8'h00},
      '{"s", "t", "o", "p", 8'h00, 8'h00},
      '{"w", "a", "r", "n", 8'h00, 8'h00},
      '{"f", "a", "u", "l", "t", 8'h00},
      '{"r", "e", "s", "e", "t", 8'h00},
      '{"s", "t", "a", "t", "u", "s"},
      '{"s", "t", "a", "c", "k", 8'h00},
      '{"h", "e", "l", "p", 8'h00, 8'h00}
   };
   localparam logic [LEN_W-1:0] KEY_LEN [KEY_COUNT] = '{
      LEN_W'(5), LEN_W'(4), LEN_W'(4), LEN_W'(5),
      LEN_W'(5), LEN_W'(6), LEN_W'(5), LEN_W'(4)
   };

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_ERASE  = 2'd1,
      OP_END    = 2'd2
   } op_type;

   typedef struct packed {
      logic       valid;
      op_type     op;
      logic [7:0] data;
   } sld_q_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } sld_entry_type;

   function automatic logic [7:0] sld_lower(input logic [7:0] c);
      if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         return c + CASE_OFS;
      end
      return c;
   endfunction

endpackage

// ----- src/sld_ram.sv -----
// Generic single-port-write, registered-read RAM
module sld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/sld_front.sv -----
// Byte classifier and operation queue in front of the line editor
module sld_front import sld_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output sld_q_type  q_head,
   input  logic       q_pop
);

   sld_entry_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              keep;
   op_type            op_cls;
   logic              push;
   logic              pop;

   always_comb begin
      keep   = 1'b1;
      op_cls = OP_APPEND;
      priority if (req_rx_byte == CHAR_CR || req_rx_byte == CHAR_LF) begin
         op_cls = OP_END;
      end else if (req_rx_byte == CHAR_BS || req_rx_byte == CHAR_DEL) begin
         op_cls = OP_ERASE;
      end else if (req_rx_byte >= CHAR_SPACE && req_rx_byte <= CHAR_TILDE) begin
         op_cls = OP_APPEND;
      end else begin
         keep = 1'b0;
      end
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall && keep;
   assign pop       = q_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{op: op_cls, data: req_rx_byte};
      end
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.op    = entry_ff[rd_ptr_ff].op;
   assign q_head.data  = entry_ff[rd_ptr_ff].data;

endmodule

// ----- src/sld_back.sv -----
// Line editor, trim scan and keyword matcher behind the queue
module sld_back import sld_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  sld_q_type  q_head,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [2:0] rsp_command_code
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_LEN   = 5'b00100,
      ST_MATCH = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  fill_ff, fill_in;
   logic [ADDR_W-1:0]  scan_ff, scan_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [ADDR_W-1:0]  chk_idx_ff, chk_idx_in;
   logic [LEN_W-1:0]   chk_pos_ff, chk_pos_in;
   logic               seen_ff, seen_in;
   logic [ADDR_W-1:0]  first_ff, first_in;
   logic [ADDR_W-1:0]  last_ff, last_in;
   logic [KEY_COUNT-1:0] mask_ff, mask_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   mpos_ff, mpos_in;
   logic [1:0]         res_kind_ff, res_kind_in;
   logic [2:0]         res_code_ff, res_code_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;
   logic [2:0]         rsp_code_ff, rsp_code_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [7:0]         rd_data;
   logic [7:0]         low_char;
   logic [ADDR_W-1:0]  len_full;
   logic [KEY_COUNT-1:0] mask_len;
   logic [KEY_COUNT-1:0] mask_cmp;
   logic [KEY_W-1:0]   hit;

   sld_ram #(.WIDTH(8), .DEPTH(LINE_CHARS)) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff),
      .wr_data (q_head.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign low_char = sld_lower(rd_data);
   assign len_full = last_ff - first_ff + ADDR_W'(1);

   always_comb begin
      mask_len = '0;
      mask_cmp = '0;
      hit      = '0;
      for (int k = 0; k < KEY_COUNT; k++) begin
         mask_len[k] = (CMP_W'(len_full) == CMP_W'(KEY_LEN[k]));
         mask_cmp[k] = mask_ff[k] && (KEY_TEXT[k][chk_pos_ff] == low_char);
      end
      // lowest surviving keyword wins
      for (int k = KEY_COUNT - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            hit = KEY_W'(k);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      scan_in      = scan_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      chk_pos_in   = chk_pos_ff;
      seen_in      = seen_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      mask_in      = mask_ff;
      len_in       = len_ff;
      mpos_in      = mpos_ff;
      res_kind_in  = res_kind_ff;
      res_code_in  = res_code_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_code_in  = rsp_code_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop = 1'b1;
               unique case (q_head.op)
                  OP_APPEND: begin
                     if (fill_ff != FILL_MAX) begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  OP_ERASE: begin
                     if (fill_ff != '0) begin
                        fill_in = fill_ff - 1'b1;
                     end
                  end
                  OP_END: begin
                     if (fill_ff != '0) begin
                        scan_in  = '0;
                        seen_in  = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            rd_addr = scan_ff;
            if (chk_valid_ff && rd_data != CHAR_SPACE) begin
               if (!seen_ff) begin
                  first_in = chk_idx_ff;
               end
               seen_in = 1'b1;
               last_in = chk_idx_ff;
            end
            if (scan_ff != fill_ff) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = scan_ff;
               scan_in      = scan_ff + 1'b1;
            end else if (!chk_valid_ff) begin
               state_in = ST_LEN;
            end
         end

         ST_LEN: begin
            if (!seen_ff || mask_len == '0) begin
               res_kind_in = KIND_INVALID;
               res_code_in = CODE_NONE;
               state_in    = ST_DONE;
            end else begin
               mask_in  = mask_len;
               len_in   = LEN_W'(len_full);
               mpos_in  = '0;
               state_in = ST_MATCH;
            end
         end

         ST_MATCH: begin
            rd_addr = first_ff + ADDR_W'(mpos_ff);
            if (chk_valid_ff) begin
               mask_in = mask_cmp;
            end
            if (mpos_ff != len_ff) begin
               chk_valid_in = 1'b1;
               chk_pos_in   = mpos_ff;
               mpos_in      = mpos_ff + 1'b1;
            end else if (!chk_valid_ff) begin
               priority if (mask_ff == '0) begin
                  res_kind_in = KIND_INVALID;
                  res_code_in = CODE_NONE;
               end else if (hit == KEY_HELP) begin
                  res_kind_in = KIND_HELP;
                  res_code_in = CODE_NONE;
               end else begin
                  res_kind_in = KIND_COMMAND;
                  res_code_in = 3'(hit);
               end
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_code_in  = res_code_ff;
               fill_in      = '0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      chk_idx_ff  <= chk_idx_in;
      chk_pos_ff  <= chk_pos_in;
      seen_ff     <= seen_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      mask_ff     <= mask_in;
      len_ff      <= len_in;
      mpos_ff     <= mpos_in;
      res_kind_ff <= res_kind_in;
      res_code_ff <= res_code_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_command_code = rsp_code_ff;

endmodule

// ----- src/serial_line_command_decoder_core.sv -----
// Serial line command decoder: top level
//
// req channel: one received byte per beat (req_rx_byte). Printable bytes
// build a line, backspace/delete erase the last character, CR or LF ends a
// non-empty line; other bytes are dropped at the front.
// rsp channel: one beat per completed line, with rsp_result_kind (command,
// help, invalid) and rsp_command_code (0 unless a command).
// Bytes pass through a 4-entry queue; the editor behind it pops edit bytes
// from it only while idle. A line end is handled in order: one RAM read
// per stored character to find the trimmed span, then, when the trimmed
// length fits a keyword, one read per keyword character, all through the
// single line RAM read port.
// req_stall rises only when the queue is full.
// The result sits in an output register; while rsp_stall is high the beat
// holds and the editor keeps consuming edit bytes, waiting only at the next
// line end. Reset (synchronous) empties the queue and the line and drops
// any pending result.
module serial_line_command_decoder_core import sld_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [2:0] rsp_command_code
);

   sld_q_type q_head;
   logic      q_pop;

   sld_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .q_head      (q_head),
      .q_pop       (q_pop)
   );

   sld_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_command_code (rsp_command_code)
   );

endmodule

// ----- src/sld_checker.sv -----
// Port-level checker for the serial line decoder, bound to the top level
`include "serial_line_command_decoder_core_defines.svh"

module sld_checker import sld_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_result_kind,
   input logic [2:0] rsp_command_code
);

   `SLD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid,
                    "rsp beat dropped")
   `SLD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall,
                    $stable(rsp_result_kind) && $stable(rsp_command_code),
                    "rsp payload moved")
   `SLD_ASSERT_NOW(a_kind_legal, clock, reset, rsp_valid, rsp_result_kind != KIND_RSVD,
                   "bad result kind")
   `SLD_ASSERT_NOW(a_code_zero, clock, reset, rsp_valid && rsp_result_kind != KIND_COMMAND,
                   rsp_command_code == CODE_NONE, "code set on non-command")
   `SLD_ASSERT_NOW(a_code_range, clock, reset, rsp_valid && rsp_result_kind == KIND_COMMAND,
                   rsp_command_code != CODE_RSVD, "command code out of range")

endmodule

bind serial_line_command_decoder_core sld_checker u_sld_checker (.*);
